// ===== src/cell_surface_depth_and_et_split_defines.svh =====
// assertion macros for the surface depth and et split block
`ifndef CELL_SURFACE_DEPTH_AND_ET_SPLIT_DEFINES_SVH
`define CELL_SURFACE_DEPTH_AND_ET_SPLIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define CSD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("csd: property failed");
// condition that must never be seen outside reset
`define CSD_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("csd: forbidden condition seen");
`else
`define CSD_ASSERT(lbl, prop)
`define CSD_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ===== src/csd_pkg.sv =====
package csd_pkg;

  // field widths
  localparam int QW       = 32;
  localparam int AreaW    = 31;
  localparam int DepW     = 21;
  localparam int FracW    = 16;
  localparam logic [DepW-1:0] DepReset = 21'd6554;

  // divider: |volume| shifted by the fraction width, one quotient bit per stage
  localparam int DivNumW  = QW + FracW;
  localparam int DivSteps = DivNumW;
  localparam int QuotW    = DivNumW + 1;

  // square root of 2*D*s, s at most D/2
  localparam int SHalfW    = DepW - 1;
  localparam int ProdW     = SHalfW + DepW + 1;
  localparam int SqrtSteps = (ProdW + 1) / 2;
  localparam int SqrtInW   = 2 * SqrtSteps;
  localparam int SqrtRemW  = SqrtSteps + 3;
  localparam int PadLen    = DivSteps - SqrtSteps;

  localparam int CurveW  = QW + 1;
  localparam int SumW    = QuotW + 3;
  localparam int Latency = DivSteps + 4;

  typedef enum logic [3:0] {
    CurvePass   = 4'b0001,
    CurveZero   = 4'b0010,
    CurveSqrt   = 4'b0100,
    CurveLinear = 4'b1000
  } curve_mode_e;

  // per-item data that rides alongside the divider
  typedef struct packed {
    curve_mode_e               mode;
    logic signed [CurveW-1:0]  alt;
    logic signed [QW-1:0]      gw;
    logic [AreaW-1:0]          depth;
    logic [AreaW-1:0]          dinf;
    logic [AreaW-1:0]          rzd;
    logic [QW-1:0]             evap;
    logic [QW-1:0]             transp;
    logic                      last;
    logic [DepW-1:0]           dep;
  } side_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi;
    logic signed [SumW-1:0] lo;
    hi = SumW'(32'sh7fffffff);
    lo = -(SumW'(64'sh80000000));
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[QW-1:0];
  endfunction

endpackage

// ===== src/csd_div.sv =====
module csd_div (
  input  logic                                 clk_i,
  input  logic [csd_pkg::DivNumW-1:0]          num_mag_i,
  input  logic                                 num_neg_i,
  input  logic [csd_pkg::AreaW-1:0]            den_i,
  output logic signed [csd_pkg::QuotW-1:0]     quot_o
);
  import csd_pkg::*;

  logic [AreaW-1:0]   rem_q  [DivSteps];
  logic [DivNumW-1:0] nq_q   [DivSteps];
  logic [AreaW-1:0]   den_q  [DivSteps];
  logic               neg_q  [DivSteps];
  logic               zero_q [DivSteps];

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DivSteps; k++) begin : g_stage
    logic [AreaW-1:0]   rem_in;
    logic [DivNumW-1:0] nq_in;
    logic [AreaW-1:0]   den_in;
    logic               neg_in;
    logic               zero_in;
    logic [AreaW:0]     trial;
    logic [AreaW+1:0]   diff;
    logic               take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign nq_in   = num_mag_i;
      assign den_in  = den_i;
      assign neg_in  = num_neg_i;
      assign zero_in = (den_i == '0);
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign neg_in  = neg_q[k-1];
      assign zero_in = zero_q[k-1];
    end

    assign trial = {rem_in, nq_in[DivNumW-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_in};
    assign take  = !diff[AreaW+1];

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? diff[AreaW-1:0] : trial[AreaW-1:0];
      nq_q[k]   <= {nq_in[DivNumW-2:0], take};
      den_q[k]  <= den_in;
      neg_q[k]  <= neg_in;
      zero_q[k] <= zero_in;
    end
  end

  // sign back on, zero area gives zero
  always_comb begin
    if (zero_q[DivSteps-1]) quot_o = '0;
    else if (neg_q[DivSteps-1]) quot_o = -$signed({1'b0, nq_q[DivSteps-1]});
    else quot_o = $signed({1'b0, nq_q[DivSteps-1]});
  end

endmodule

// ===== src/csd_sqrt.sv =====
module csd_sqrt (
  input  logic                             clk_i,
  input  logic [csd_pkg::SqrtInW-1:0]      rad_i,
  output logic [csd_pkg::SqrtSteps-1:0]    root_o
);
  import csd_pkg::*;

  logic [SqrtRemW-1:0]  rem_q  [SqrtSteps];
  logic [SqrtSteps-1:0] root_q [SqrtSteps];
  logic [SqrtInW-1:0]   rad_q  [SqrtSteps];

  // digit-by-digit integer square root, one root bit per stage
  for (genvar k = 0; k < SqrtSteps; k++) begin : g_stage
    logic [SqrtRemW-1:0]  rem_in;
    logic [SqrtSteps-1:0] root_in;
    logic [SqrtInW-1:0]   rad_in;
    logic [SqrtRemW-1:0]  rem_t;
    logic [SqrtRemW-1:0]  trial;
    logic                 take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end

    assign rem_t = {rem_in[SqrtRemW-3:0], rad_in[SqrtInW-1:SqrtInW-2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign take  = (rem_t >= trial);

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= take ? (rem_t - trial) : rem_t;
      root_q[k] <= {root_in[SqrtSteps-2:0], take};
      rad_q[k]  <= {rad_in[SqrtInW-3:0], 2'b00};
    end
  end

  assign root_o = root_q[SqrtSteps-1];

endmodule

// ===== src/cell_surface_depth_and_et_split.sv =====
// Per-cell surface depth and evapotranspiration split, signed Q16.16.
// Input channel: an item is taken at a rising edge with start high and busy
// low. busy stays low, so one item can enter in every cycle.
// Result channel: done_o is high for exactly one cycle with the result word
// on the output ports; the receiver takes it at the edge ending that cycle
// and cannot stall the block, so the pipeline never holds.
// Throughput: one item per cycle. The pipeline length is set by the three
// inflow dividers, 48 stages each with one quotient bit per stage; the
// 21-stage square root is padded to line up with them.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_data_i writes the
// depression storage register; cfg_ready_o is always high. Write it only
// while no items are in flight.
// Reset: clears all valid bits, so no stale results appear, and loads the
// depression storage register with its default of 6554.
module cell_surface_depth_and_et_split (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [csd_pkg::QW-1:0]     equiv_surface_depth_i,
  input  logic signed [csd_pkg::QW-1:0]     upstream_surface_volume_i,
  input  logic signed [csd_pkg::QW-1:0]     upstream_subsurface_volume_i,
  input  logic signed [csd_pkg::QW-1:0]     upstream_ground_volume_i,
  input  logic [csd_pkg::AreaW-1:0]         cell_area_i,
  input  logic signed [csd_pkg::QW-1:0]     ground_head_i,
  input  logic [csd_pkg::AreaW-1:0]         soil_depth_i,
  input  logic [csd_pkg::AreaW-1:0]         infiltration_depth_i,
  input  logic [csd_pkg::AreaW-1:0]         root_zone_depth_i,
  input  logic signed [csd_pkg::QW-1:0]     evap_rate_i,
  input  logic signed [csd_pkg::QW-1:0]     transp_rate_i,
  input  logic                              last_cell_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [csd_pkg::DepW-1:0]          cfg_data_i,
  output logic                              done_o,
  output logic signed [csd_pkg::QW-1:0]     surface_depth_o,
  output logic signed [csd_pkg::QW-1:0]     new_ground_head_o,
  output logic signed [csd_pkg::QW-1:0]     evap_surface_o,
  output logic signed [csd_pkg::QW-1:0]     evap_unsat_o,
  output logic signed [csd_pkg::QW-1:0]     evap_ground_o,
  output logic signed [csd_pkg::QW-1:0]     transp_unsat_o,
  output logic signed [csd_pkg::QW-1:0]     transp_ground_o,
  output logic                              last_cell_out_o
);
  import csd_pkg::*;
  `include "cell_surface_depth_and_et_split_defines.svh"

  logic accept;
  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // depression storage register
  logic [DepW-1:0] dep_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dep_q <= DepReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dep_q <= cfg_data_i;
    end
  end

  // stage 1: input register
  logic                     v1_q;
  logic signed [QW-1:0]     s1_q, vs1_q, vss1_q, vg1_q, gw1_q;
  logic [AreaW-1:0]         area1_q, depth1_q, dinf1_q, rzd1_q;
  logic [QW-1:0]            evap1_q, transp1_q;
  logic                     last1_q;
  logic [DepW-1:0]          dep1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else v1_q <= accept;
  end

  always_ff @(posedge clk_i) begin
    s1_q      <= equiv_surface_depth_i;
    vs1_q     <= upstream_surface_volume_i;
    vss1_q    <= upstream_subsurface_volume_i;
    vg1_q     <= upstream_ground_volume_i;
    area1_q   <= cell_area_i;
    gw1_q     <= ground_head_i;
    depth1_q  <= soil_depth_i;
    dinf1_q   <= infiltration_depth_i;
    rzd1_q    <= root_zone_depth_i;
    evap1_q   <= evap_rate_i;
    transp1_q <= transp_rate_i;
    last1_q   <= last_cell_i;
    dep1_q    <= dep_q;
  end

  // stage 2: curve branch, product for the root, dividend magnitudes
  curve_mode_e              mode1;
  logic signed [CurveW-1:0] alt1;
  logic [QW:0]              two_s;
  logic [ProdW-2:0]         prod1;

  always_comb begin
    two_s = {s1_q, 1'b0};
    if (dep1_q == '0) mode1 = CurvePass;
    else if (s1_q[QW-1]) mode1 = CurveZero;
    else if (two_s <= {{(QW+1-DepW){1'b0}}, dep1_q}) mode1 = CurveSqrt;
    else mode1 = CurveLinear;
  end

  always_comb begin
    case (mode1)
      CurvePass:   alt1 = CurveW'(s1_q);
      CurveLinear: alt1 = CurveW'(s1_q) + $signed({{(CurveW-DepW+1){1'b0}}, dep1_q[DepW-1:1]});
      default:     alt1 = '0;
    endcase
  end

  assign prod1 = s1_q[SHalfW-1:0] * dep1_q;

  function automatic logic [DivNumW-1:0] vol_mag(input logic signed [QW-1:0] v);
    logic [QW-1:0] m;
    m = v[QW-1] ? (~v + 1'b1) : v;
    return {m, {FracW{1'b0}}};
  endfunction

  logic                 v2_q;
  side_t                side2_q;
  logic [SqrtInW-1:0]   rad2_q;
  logic [DivNumW-1:0]   mag_s2_q, mag_ss2_q, mag_g2_q;
  logic                 neg_s2_q, neg_ss2_q, neg_g2_q;
  logic [AreaW-1:0]     area2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    side2_q.mode   <= mode1;
    side2_q.alt    <= alt1;
    side2_q.gw     <= gw1_q;
    side2_q.depth  <= depth1_q;
    side2_q.dinf   <= dinf1_q;
    side2_q.rzd    <= rzd1_q;
    side2_q.evap   <= evap1_q;
    side2_q.transp <= transp1_q;
    side2_q.last   <= last1_q;
    side2_q.dep    <= dep1_q;
    rad2_q    <= SqrtInW'({prod1, 1'b0});
    mag_s2_q  <= vol_mag(vs1_q);
    mag_ss2_q <= vol_mag(vss1_q);
    mag_g2_q  <= vol_mag(vg1_q);
    neg_s2_q  <= vs1_q[QW-1];
    neg_ss2_q <= vss1_q[QW-1];
    neg_g2_q  <= vg1_q[QW-1];
    area2_q   <= area1_q;
  end

  // inflow dividers
  logic signed [QuotW-1:0] q_s, q_ss, q_g;

  csd_div u_div_surf (
    .clk_i     (clk_i),
    .num_mag_i (mag_s2_q),
    .num_neg_i (neg_s2_q),
    .den_i     (area2_q),
    .quot_o    (q_s)
  );

  csd_div u_div_sub (
    .clk_i     (clk_i),
    .num_mag_i (mag_ss2_q),
    .num_neg_i (neg_ss2_q),
    .den_i     (area2_q),
    .quot_o    (q_ss)
  );

  csd_div u_div_gnd (
    .clk_i     (clk_i),
    .num_mag_i (mag_g2_q),
    .num_neg_i (neg_g2_q),
    .den_i     (area2_q),
    .quot_o    (q_g)
  );

  // square root, then padded to the divider latency
  logic [SqrtSteps-1:0] root;
  logic [SqrtSteps-1:0] pad_q [PadLen];

  csd_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (rad2_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    pad_q[0] <= root;
    for (int i = 1; i < PadLen; i++) pad_q[i] <= pad_q[i-1];
  end

  // side data and valid bits along the divider
  side_t side_q [DivSteps];
  logic  vd_q   [DivSteps];

  always_ff @(posedge clk_i) begin
    side_q[0] <= side2_q;
    for (int i = 1; i < DivSteps; i++) side_q[i] <= side_q[i-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DivSteps; i++) vd_q[i] <= 1'b0;
    end else begin
      vd_q[0] <= v2_q;
      for (int i = 1; i < DivSteps; i++) vd_q[i] <= vd_q[i-1];
    end
  end

  // sum stage: curve plus inflows, saturated once
  side_t                    sd;
  logic signed [CurveW-1:0] curve_val;
  logic signed [SumW-1:0]   surf_sum, gw_sum;

  assign sd = side_q[DivSteps-1];

  always_comb begin
    if (sd.mode == CurveSqrt) curve_val = $signed({{(CurveW-SqrtSteps){1'b0}}, pad_q[PadLen-1]});
    else curve_val = sd.alt;
    surf_sum = SumW'(curve_val) + SumW'(q_s);
    gw_sum   = SumW'(sd.gw) + SumW'(q_ss) + SumW'(q_g);
  end

  logic                 v3_q;
  side_t                side3_q;
  logic signed [QW-1:0] surf3_q, gwn3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else v3_q <= vd_q[DivSteps-1];
  end

  always_ff @(posedge clk_i) begin
    side3_q <= sd;
    surf3_q <= sat32(surf_sum);
    gwn3_q  <= sat32(gw_sum);
  end

  // source selection by depth comparisons
  logic signed [QW:0] evap_lim, transp_lim;
  logic               to_surf, evap_to_gnd, transp_to_gnd;

  assign evap_lim      = $signed({2'b00, side3_q.depth}) - $signed({2'b00, side3_q.dinf});
  assign transp_lim    = $signed({2'b00, side3_q.depth}) - $signed({2'b00, side3_q.rzd});
  assign to_surf       = (QW+1)'(surf3_q) >= $signed({{(QW+1-DepW){1'b0}}, side3_q.dep});
  assign evap_to_gnd   = (QW+1)'(gwn3_q) > evap_lim;
  assign transp_to_gnd = (QW+1)'(gwn3_q) > transp_lim;

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o            <= 1'b0;
      surface_depth_o   <= '0;
      new_ground_head_o <= '0;
      evap_surface_o    <= '0;
      evap_unsat_o      <= '0;
      evap_ground_o     <= '0;
      transp_unsat_o    <= '0;
      transp_ground_o   <= '0;
      last_cell_out_o   <= 1'b0;
    end else begin
      done_o            <= v3_q;
      surface_depth_o   <= surf3_q;
      new_ground_head_o <= gwn3_q;
      evap_surface_o    <= to_surf ? side3_q.evap : '0;
      evap_ground_o     <= (!to_surf && evap_to_gnd) ? side3_q.evap : '0;
      evap_unsat_o      <= (!to_surf && !evap_to_gnd) ? side3_q.evap : '0;
      transp_ground_o   <= transp_to_gnd ? side3_q.transp : '0;
      transp_unsat_o    <= transp_to_gnd ? '0 : side3_q.transp;
      last_cell_out_o   <= side3_q.last;
    end
  end

  // checks
  `CSD_ASSERT(a_done_latency, done_o |-> $past(start && !busy, Latency))
  `CSD_ASSERT(a_evap_one_src, $onehot0({evap_surface_o != '0, evap_unsat_o != '0, evap_ground_o != '0}))
  `CSD_ASSERT_NEVER(a_transp_both, transp_unsat_o != '0 && transp_ground_o != '0)

endmodule

// ===== test/cell_surface_depth_and_et_split_tb.sv =====
`timescale 1ns / 1ps

module cell_surface_depth_and_et_split_tb;
  import csd_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = Latency + 8;

  // one input word
  typedef struct {
    logic signed [31:0] s;
    logic signed [31:0] vs;
    logic signed [31:0] vss;
    logic signed [31:0] vg;
    logic [30:0]        area;
    logic signed [31:0] gw;
    logic [30:0]        depth;
    logic [30:0]        dinf;
    logic [30:0]        rzd;
    logic signed [31:0] evap;
    logic signed [31:0] transp;
    logic               last;
  } cell_t;

  // one result word
  typedef struct {
    logic signed [31:0] surf;
    logic signed [31:0] gwn;
    logic signed [31:0] es;
    logic signed [31:0] eu;
    logic signed [31:0] eg;
    logic signed [31:0] tu;
    logic signed [31:0] tg;
    logic               last;
  } split_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] equiv_surface_depth_i = '0;
  logic signed [31:0] upstream_surface_volume_i = '0;
  logic signed [31:0] upstream_subsurface_volume_i = '0;
  logic signed [31:0] upstream_ground_volume_i = '0;
  logic [30:0] cell_area_i = 31'd1;
  logic signed [31:0] ground_head_i = '0;
  logic [30:0] soil_depth_i = '0;
  logic [30:0] infiltration_depth_i = '0;
  logic [30:0] root_zone_depth_i = '0;
  logic signed [31:0] evap_rate_i = '0;
  logic signed [31:0] transp_rate_i = '0;
  logic last_cell_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [20:0] cfg_data_i = '0;
  logic done_o;
  logic signed [31:0] surface_depth_o, new_ground_head_o;
  logic signed [31:0] evap_surface_o, evap_unsat_o, evap_ground_o;
  logic signed [31:0] transp_unsat_o, transp_ground_o;
  logic last_cell_out_o;

  cell_surface_depth_and_et_split u_dut (.*);

  // clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  cell_t  pending_cells[$];
  split_t expected_splits[$];
  logic [20:0] storage_depth = DepReset;
  int  send_idle_pct = 0;
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  cfg_pending = 0;
  logic [20:0] cfg_value;
  bit  cfg_sent = 0;

  function automatic longint isqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint depth_per_area(longint vol, longint area);
    if (area == 0) return 0;
    return (vol * 65536) / area;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // expected split of one cell under the current storage depth
  function automatic split_t predict_split(cell_t c, logic [20:0] dep);
    split_t r;
    longint d, s, cv, surf, gwn;
    d = longint'(dep);
    s = longint'(c.s);
    if (d == 0) cv = s;
    else if (s < 0) cv = 0;
    else if (2 * s <= d) cv = isqrt(longint'(2 * d) * s);
    else cv = s + (d >>> 1);
    surf = clamp32(cv + depth_per_area(longint'(c.vs), longint'(c.area)));
    gwn = clamp32(longint'(c.gw) + depth_per_area(longint'(c.vss), longint'(c.area))
                  + depth_per_area(longint'(c.vg), longint'(c.area)));
    r.surf = surf[31:0];
    r.gwn = gwn[31:0];
    r.es = 0; r.eu = 0; r.eg = 0; r.tu = 0; r.tg = 0;
    if (surf >= d) r.es = c.evap;
    else if (gwn > longint'(c.depth) - longint'(c.dinf)) r.eg = c.evap;
    else r.eu = c.evap;
    if (gwn > longint'(c.depth) - longint'(c.rzd)) r.tg = c.transp;
    else r.tu = c.transp;
    r.last = c.last;
    return r;
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h0004_0000);
      3: return -$urandom_range(0, 32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c.s = ($urandom_range(0, 2) == 0) ? rand_q() : $urandom_range(0, 32'h0003_0000);
    c.vs = rand_q();
    c.vss = rand_q();
    c.vg = rand_q();
    case ($urandom_range(0, 4))
      0: c.area = 31'd1;
      1: c.area = 31'h7fffffff;
      2: c.area = 31'd0;
      default: c.area = 31'($urandom);
    endcase
    c.gw = rand_q();
    c.depth = 31'($urandom);
    c.dinf = 31'($urandom);
    c.rzd = 31'($urandom);
    if ($urandom_range(0, 1)) begin
      c.depth = 31'($urandom_range(0, 32'h0010_0000));
      c.dinf = 31'($urandom_range(0, 32'(c.depth)));
      c.rzd = 31'($urandom_range(0, 32'(c.depth)));
      c.gw = $urandom_range(0, 32'h0010_0000);
    end
    c.evap = $urandom;
    c.transp = $urandom;
    c.last = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic cell_t make_cell(logic signed [31:0] s, logic signed [31:0] v,
                                      logic [30:0] area);
    cell_t c;
    c = rand_cell();
    c.s = s;
    c.vs = v;
    c.vss = v;
    c.vg = v;
    c.area = area;
    return c;
  endfunction

  // driver: one word per accepted edge, changes at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (cfg_pending && !cfg_sent) begin
        cfg_valid_i <= 1'b1;
        cfg_data_i <= cfg_value;
        cfg_sent = 1;
      end else if (cfg_valid_i && cfg_ready_o) begin
        cfg_valid_i <= 1'b0;
      end
      if (start && !busy) void'(pending_cells.pop_front());
      if (pending_cells.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        start <= 1'b1;
        equiv_surface_depth_i <= pending_cells[0].s;
        upstream_surface_volume_i <= pending_cells[0].vs;
        upstream_subsurface_volume_i <= pending_cells[0].vss;
        upstream_ground_volume_i <= pending_cells[0].vg;
        cell_area_i <= pending_cells[0].area;
        ground_head_i <= pending_cells[0].gw;
        soil_depth_i <= pending_cells[0].depth;
        infiltration_depth_i <= pending_cells[0].dinf;
        root_zone_depth_i <= pending_cells[0].rzd;
        evap_rate_i <= pending_cells[0].evap;
        transp_rate_i <= pending_cells[0].transp;
        last_cell_i <= pending_cells[0].last;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on accept, compare on strobe
  always @(posedge clk_i) begin
    split_t e;
    cell_t c;
    bit seen;
    seen = 0;
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      storage_depth <= cfg_data_i;
      cfg_pending = 0;
      cfg_sent = 0;
    end
    if (rst_ni && start && !busy) begin
      c.s = equiv_surface_depth_i; c.vs = upstream_surface_volume_i;
      c.vss = upstream_subsurface_volume_i; c.vg = upstream_ground_volume_i;
      c.area = cell_area_i; c.gw = ground_head_i; c.depth = soil_depth_i;
      c.dinf = infiltration_depth_i; c.rzd = root_zone_depth_i;
      c.evap = evap_rate_i; c.transp = transp_rate_i; c.last = last_cell_i;
      expected_splits.push_back(predict_split(c, storage_depth));
      seen = 1;
    end
    if (rst_ni && done_o) begin
      seen = 1;
      if (expected_splits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual surf=%h", $time,
                 surface_depth_o);
        errors++;
      end else begin
        e = expected_splits.pop_front();
        if ({surface_depth_o, new_ground_head_o, evap_surface_o, evap_unsat_o,
             evap_ground_o, transp_unsat_o, transp_ground_o, last_cell_out_o} !==
            {e.surf, e.gwn, e.es, e.eu, e.eg, e.tu, e.tg, e.last}) begin
          $display("%0t: mismatch expected %h %h %h %h %h %h %h %b", $time,
                   e.surf, e.gwn, e.es, e.eu, e.eg, e.tu, e.tg, e.last);
          $display("%0t: mismatch actual   %h %h %h %h %h %h %h %b", $time,
                   surface_depth_o, new_ground_head_o, evap_surface_o, evap_unsat_o,
                   evap_ground_o, transp_unsat_o, transp_ground_o, last_cell_out_o);
          errors++;
        end
      end
    end
    quiet_cycles <= seen ? 0 : quiet_cycles + 1;
  end

  // watchdog
  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain();
    while (pending_cells.size() != 0 || expected_splits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_storage(logic [20:0] v);
    cfg_value = v;
    cfg_pending = 1;
    while (cfg_pending) @(posedge clk_i);
  endtask

  initial begin
    logic [20:0] settings[6];
    int pct[4];
    settings = '{21'd0, 21'd1048576, 21'd6554, 21'd1, 21'd65536, 21'h1fffff};
    pct = '{0, 87, 0, 35};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: curve branches, extremes, zero area, saturation
    pending_cells.push_back(make_cell(32'sd0, 32'sd0, 31'd65536));
    pending_cells.push_back(make_cell(-32'sd1, 32'sd0, 31'd65536));
    pending_cells.push_back(make_cell(32'sd3277, 32'sd0, 31'd65536));
    pending_cells.push_back(make_cell(32'sd3278, 32'sd0, 31'd65536));
    pending_cells.push_back(make_cell(32'sd100, 32'sd0, 31'd65536));
    pending_cells.push_back(make_cell(32'sh7fffffff, 32'sh7fffffff, 31'd1));
    pending_cells.push_back(make_cell(32'sh80000000, 32'sh80000000, 31'd1));
    pending_cells.push_back(make_cell(32'sh7fffffff, 32'sh7fffffff, 31'd0));
    pending_cells.push_back(make_cell(32'sd5, -32'sd7, 31'h7fffffff));
    pending_cells.push_back(make_cell(32'sd5, -32'sd70000, 31'd3));
    for (int i = 0; i < 8; i++) pending_cells.push_back(rand_cell());
    drain();

    // random phases over several storage depths and idle patterns
    for (int p = 0; p < 6; p++) begin
      write_storage(settings[p]);
      pending_cells.push_back(make_cell(32'(settings[p] >> 1), 32'sd0, 31'd65536));
      pending_cells.push_back(make_cell(32'(settings[p] >> 1) + 1, 32'sd0, 31'd65536));
      for (int k = 0; k < 4; k++) begin
        send_idle_pct = pct[k];
        for (int i = 0; i < 19; i++) pending_cells.push_back(rand_cell());
        while (pending_cells.size() != 0) @(posedge clk_i);
      end
      drain();
    end

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
